>>> design/gcm_pkg.sv
// Package for the gradient colour map unit: operation and status codes, FSM states.
// Depends on nothing; used by the top module of the block.
package gcm_pkg;

  localparam int MaxStops    = 256;
  localparam int PosFracBits = 16;
  localparam int SampleBits  = 16;

  typedef enum logic [1:0] {
    OP_MAP    = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MDIV,
    S_SRCH_RD,
    S_SRCH_WT,
    S_SRCH_CMP,
    S_INS_CHK_RD,
    S_INS_CHK_WT,
    S_SHIFT_RD,
    S_SHIFT_WT,
    S_SHIFT_WR,
    S_INS_WR,
    S_MAP_RD0,
    S_MAP_RD1,
    S_MAP_WT,
    S_MAP_DIFF,
    S_MAP_DIV,
    S_OUT
  } state_t;

  localparam logic [1:0] RegScaled = 2'd0;
  localparam logic [1:0] RegLow    = 2'd1;
  localparam logic [1:0] RegHigh   = 2'd2;

endpackage

>>> design/gradient_color_map_unit.sv
// Gradient colour map unit. Holds a sorted table of up to MAX_STOPS colour stops
// (Q16 position, RGBA) in two single-port RAMs and serves three operations on the
// s_ beat: map a sample, insert a stop, clear the table. One result beat on m_ for
// every input beat. Items are handled one at a time. A map runs the sample scaling
// divide when the sample lies inside the range, a read, a wait and a compare per
// binary search step (log2 of the stop count steps) plus a final state to leave
// the search, a fetch of the two enclosing stops, and one interpolation divide per
// channel when it interpolates; an insert runs the search, then moves each stop up
// with a read, a wait and a write on the shared RAM port.
// Stop RAM contents are undefined after reset; only entries below the stop count
// are used. Config registers must only be written over APB while the block is idle;
// the block itself does not enforce this.
// Depends on gcm_pkg, gcm_ram, gcm_div.
module gradient_color_map_unit #(
  parameter int MAX_STOPS     = gcm_pkg::MaxStops,
  parameter int POS_FRAC_BITS = gcm_pkg::PosFracBits,
  parameter int SAMPLE_BITS   = gcm_pkg::SampleBits
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: operation[1:0], sample, stop_position(POS_FRAC_BITS+1), red, green,
  // blue, alpha, zero-padded to whole bytes
  input  logic [((2+SAMPLE_BITS+POS_FRAC_BITS+1+32+7)/8)*8-1:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24], status[33:32]
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int PosW  = POS_FRAC_BITS + 1;
  localparam int IdxW  = $clog2(MAX_STOPS);
  localparam int CntW  = $clog2(MAX_STOPS + 1);
  localparam int InW   = ((2+SAMPLE_BITS+PosW+32+7)/8)*8;
  localparam int DivW  = SAMPLE_BITS + POS_FRAC_BITS + 2;
  localparam int DiffW = SAMPLE_BITS + 1;
  localparam logic [PosW-1:0] PosOne = PosW'(1) << POS_FRAC_BITS;
  // replace window: (p - pos)*1000 < one, i.e. p - pos <= floor((one-1)/1000)
  localparam logic [PosW-1:0] NearLim = PosW'(((1 << POS_FRAC_BITS) - 1) / 1000);

  // ---------------- configuration ----------------
  logic                          scaled_mode;
  logic signed [SAMPLE_BITS-1:0] range_low, range_high;
  logic                          cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_mode <= 1'b1;
      range_low   <= '0;
      range_high  <= SAMPLE_BITS'(255);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        gcm_pkg::RegScaled: scaled_mode <= pwdata[0];
        gcm_pkg::RegLow:    range_low   <= pwdata[SAMPLE_BITS-1:0];
        gcm_pkg::RegHigh:   range_high  <= pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gcm_pkg::RegScaled: prdata = {31'd0, scaled_mode};
      gcm_pkg::RegLow:    prdata = 32'(signed'(range_low));
      gcm_pkg::RegHigh:   prdata = 32'(signed'(range_high));
      default:            prdata = '0;
    endcase
  end

  // ---------------- input fields ----------------
  gcm_pkg::op_t                  in_op;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [PosW-1:0]               in_pos;
  logic [31:0]                   in_rgba;
  assign in_op     = gcm_pkg::op_t'(s_tdata[1:0]);
  assign in_sample = s_tdata[2 +: SAMPLE_BITS];
  assign in_pos    = s_tdata[2+SAMPLE_BITS +: PosW];
  // stored colour word: red high byte, alpha low byte
  assign in_rgba   = {s_tdata[2+SAMPLE_BITS+PosW +: 8], s_tdata[2+SAMPLE_BITS+PosW+8 +: 8],
                      s_tdata[2+SAMPLE_BITS+PosW+16 +: 8], s_tdata[2+SAMPLE_BITS+PosW+24 +: 8]};

  logic unused_pad;
  assign unused_pad = ^s_tdata[InW-1:2+SAMPLE_BITS+PosW+32] ^ ^pwdata[31:SAMPLE_BITS];

  // ---------------- stop RAMs ----------------
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [PosW-1:0] pos_wdata, pos_rdata;
  logic [31:0]     col_wdata, col_rdata;

  gcm_ram #(.Width(PosW), .Depth(MAX_STOPS)) u_pos_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(pos_wdata), .rdata(pos_rdata));
  gcm_ram #(.Width(32), .Depth(MAX_STOPS)) u_col_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(col_wdata), .rdata(col_rdata));

  // ---------------- shared divider ----------------
  logic            div_start, div_done;
  logic [DivW-1:0] div_num, div_den, div_quot;

  gcm_div #(.Bits(DivW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot));

  // ---------------- item registers ----------------
  gcm_pkg::state_t state, state_next;
  gcm_pkg::op_t    op;
  logic [PosW-1:0] key;          // search key: insert position or mapped position
  logic [31:0]     rgba;
  logic [CntW-1:0] stop_count;
  logic            alpha_seen;
  logic [CntW-1:0] lo, n;        // binary search window
  logic [CntW-1:0] mv;           // shift pointer, walks down from stop_count
  logic [PosW-1:0] p0;
  logic [31:0]     c0, c1;
  logic [PosW:0]   dp, ps;
  logic [1:0]      chn;          // channel under interpolation
  logic [1:0]      csel;         // channel fed to the divider this cycle
  logic [7:0]      res [4];
  logic [1:0]      status;
  logic [CntW-1:0] mid;
  logic signed [DiffW-1:0] num_s, den_s;
  logic [7:0]      ch0, ch1;
  logic signed [9:0] cdiff;
  logic            chk_first;    // first shift pass: decide replace or new entry
  logic            chk_near;
  // when the lower-stop path was taken, the divider result is discarded
  logic            lerp_done_skip;
  logic            lerp_active;

  assign mid   = lo + (n >> 1);
  assign num_s = DiffW'(in_sample) - DiffW'(range_low);
  assign den_s = DiffW'(range_high) - DiffW'(range_low);
  // a divide is launched on the done beat of the previous one, so look one channel ahead
  assign csel  = (state == gcm_pkg::S_MAP_DIV) ? chn + 2'd1 : chn;
  assign ch0   = c0[8*(3-csel) +: 8];
  assign ch1   = c1[8*(3-csel) +: 8];
  assign cdiff = 10'(ch1) - 10'(ch0);
  assign chk_first = mv == stop_count && lo < stop_count && !(p0 == '1);
  assign chk_near  = pos_rdata - key <= NearLim;

  // interpolation as floor((ps*(2c0+1) + 2dp(c1-c0)) / 2ps); numerator is never
  // negative since dp <= ps, so an unsigned divide suffices
  logic signed [DivW-1:0] lerp_num;
  assign lerp_num = DivW'(signed'({1'b0, ps})) * DivW'(signed'({2'b0, ch0, 1'b1}))
                  + DivW'(signed'({1'b0, dp, 1'b0})) * DivW'(cdiff);

  assign s_tready = (state == gcm_pkg::S_IDLE) && !m_tvalid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gcm_pkg::S_IDLE:
        if (s_tvalid && s_tready) begin
          case (in_op)
            gcm_pkg::OP_MAP:
              if (den_s <= 0 || stop_count == '0 || num_s <= 0 || num_s >= den_s)
                state_next = gcm_pkg::S_MAP_RD0;
              else state_next = gcm_pkg::S_MDIV;
            gcm_pkg::OP_INSERT:
              state_next = (in_pos > PosOne) ? gcm_pkg::S_OUT : gcm_pkg::S_SRCH_RD;
            default: state_next = gcm_pkg::S_OUT;
          endcase
        end
      gcm_pkg::S_MDIV:     if (div_done) state_next = gcm_pkg::S_SRCH_RD;
      gcm_pkg::S_SRCH_RD:
        if (n == '0) begin
          if (op == gcm_pkg::OP_INSERT) state_next = gcm_pkg::S_INS_CHK_RD;
          else state_next = gcm_pkg::S_MAP_RD0;
        end else state_next = gcm_pkg::S_SRCH_WT;
      gcm_pkg::S_SRCH_WT:  state_next = gcm_pkg::S_SRCH_CMP;
      gcm_pkg::S_SRCH_CMP: state_next = gcm_pkg::S_SRCH_RD;
      gcm_pkg::S_INS_CHK_RD:
        state_next = (lo >= stop_count) ? gcm_pkg::S_SHIFT_RD : gcm_pkg::S_INS_CHK_WT;
      gcm_pkg::S_INS_CHK_WT: state_next = gcm_pkg::S_SHIFT_RD;
      gcm_pkg::S_SHIFT_RD:
        if (status == gcm_pkg::ST_FULL) state_next = gcm_pkg::S_OUT;
        else if (chk_first && chk_near) state_next = gcm_pkg::S_INS_WR;
        else if (chk_first && stop_count == CntW'(MAX_STOPS)) state_next = gcm_pkg::S_OUT;
        else if (mv > lo) state_next = gcm_pkg::S_SHIFT_WT;
        else state_next = gcm_pkg::S_INS_WR;
      gcm_pkg::S_SHIFT_WT: state_next = gcm_pkg::S_SHIFT_WR;
      gcm_pkg::S_SHIFT_WR: state_next = gcm_pkg::S_SHIFT_RD;
      gcm_pkg::S_INS_WR:   state_next = gcm_pkg::S_OUT;
      gcm_pkg::S_MAP_RD0:  state_next = gcm_pkg::S_MAP_RD1;
      gcm_pkg::S_MAP_RD1:  state_next = gcm_pkg::S_MAP_WT;
      gcm_pkg::S_MAP_WT:   state_next = gcm_pkg::S_MAP_DIFF;
      gcm_pkg::S_MAP_DIFF: state_next = gcm_pkg::S_MAP_DIV;
      gcm_pkg::S_MAP_DIV:
        if (div_done && chn == 2'd3) state_next = gcm_pkg::S_OUT;
      gcm_pkg::S_OUT:      if (m_tvalid && m_tready) state_next = gcm_pkg::S_IDLE;
      default:             state_next = gcm_pkg::S_IDLE;
    endcase
  end

  // RAM and divider controls
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = mid[IdxW-1:0];
    pos_wdata = key;
    col_wdata = rgba;
    div_start = 1'b0;
    div_num   = DivW'(num_s) << POS_FRAC_BITS;
    div_den   = DivW'(den_s);
    case (state)
      gcm_pkg::S_IDLE:
        div_start = s_tvalid && s_tready && in_op == gcm_pkg::OP_MAP && den_s > 0 &&
                    stop_count != '0 && num_s > 0 && num_s < den_s;
      gcm_pkg::S_INS_CHK_RD, gcm_pkg::S_INS_WR: begin
        ram_addr = lo[IdxW-1:0];
        ram_we   = (state == gcm_pkg::S_INS_WR);
      end
      gcm_pkg::S_SHIFT_RD: ram_addr = IdxW'(mv - 1'b1);
      gcm_pkg::S_SHIFT_WR: begin
        ram_addr  = mv[IdxW-1:0];
        ram_we    = 1'b1;
        pos_wdata = p0;
        col_wdata = c0;
      end
      gcm_pkg::S_MAP_RD0: ram_addr = IdxW'(lo - 1'b1);
      gcm_pkg::S_MAP_RD1: ram_addr = lo[IdxW-1:0];
      gcm_pkg::S_MAP_DIFF: begin
        div_start = 1'b1;
        div_num   = DivW'(lerp_num);
        div_den   = DivW'({ps, 1'b0});
      end
      gcm_pkg::S_MAP_DIV: begin
        div_start = div_done && chn != 2'd3;
        div_num   = DivW'(lerp_num);
        div_den   = DivW'({ps, 1'b0});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gcm_pkg::S_IDLE;
      stop_count <= '0;
      alpha_seen <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      else if (state_next == gcm_pkg::S_OUT && state != gcm_pkg::S_OUT) m_tvalid <= 1'b1;
      if (state == gcm_pkg::S_IDLE && s_tvalid && s_tready && in_op == gcm_pkg::OP_CLEAR) begin
        stop_count <= '0;
        alpha_seen <= 1'b0;
      end
      if (state == gcm_pkg::S_INS_WR) begin
        if (!(p0 == '1)) stop_count <= stop_count + 1'b1;
        if (rgba[7:0] != 8'hFF) alpha_seen <= 1'b1;
      end
    end
  end

  // datapath registers; p0 all-ones doubles as the "replace" mark after the check
  always_ff @(posedge clk) begin
    case (state)
      gcm_pkg::S_IDLE:
        if (s_tvalid && s_tready) begin
          op     <= in_op;
          key    <= in_pos;
          rgba   <= in_rgba;
          lo     <= '0;
          n      <= stop_count;
          mv     <= stop_count;
          chn    <= 2'd0;
          status <= gcm_pkg::ST_OK;
          for (int i = 0; i < 4; i++) res[i] <= 8'd0;
          if (in_op == gcm_pkg::OP_INSERT && in_pos > PosOne) status <= gcm_pkg::ST_RANGE;
          if (in_op == gcm_pkg::OP_MAP) begin
            if (den_s <= 0) status <= gcm_pkg::ST_EMPTY;
            else if (stop_count == '0) begin
              res[0] <= 8'd128; res[1] <= 8'd128; res[2] <= 8'd128; res[3] <= 8'd255;
            end else if (num_s <= 0) lo <= '0;
            else if (num_s >= den_s) lo <= stop_count;
          end
        end
      gcm_pkg::S_MDIV:
        if (div_done) key <= div_quot[PosW-1:0];
      gcm_pkg::S_SRCH_CMP:
        if (pos_rdata <= key) begin
          lo <= mid + 1'b1;
          n  <= n - (n >> 1) - 1'b1;
        end else n <= n >> 1;
      gcm_pkg::S_INS_CHK_RD: begin
        p0 <= '0;
        if (lo >= stop_count && stop_count == CntW'(MAX_STOPS)) status <= gcm_pkg::ST_FULL;
      end
      gcm_pkg::S_INS_CHK_WT: ;
      gcm_pkg::S_SHIFT_RD:
        if (chk_first) begin
          // first pass: decide replace versus new entry from the looked-up stop
          if (chk_near) begin
            p0 <= '1;
            mv <= lo;
          end else if (stop_count == CntW'(MAX_STOPS)) status <= gcm_pkg::ST_FULL;
        end
      gcm_pkg::S_SHIFT_WT: begin
        p0 <= pos_rdata;
        c0 <= col_rdata;
      end
      gcm_pkg::S_SHIFT_WR: mv <= mv - 1'b1;
      gcm_pkg::S_MAP_WT: c1 <= col_rdata;
      gcm_pkg::S_MAP_DIFF: begin
        p0 <= pos_rdata;
        if (status == gcm_pkg::ST_OK && stop_count != '0) begin
          if (lo == '0 || lo >= stop_count || !scaled_mode) begin
            // use the lower stop, or the clamped end stop
            for (int i = 0; i < 4; i++) res[i] <= (lo == '0) ? c1[8*(3-i) +: 8]
                                                             : c0[8*(3-i) +: 8];
            chn <= 2'd3;
          end
        end else chn <= 2'd3;
      end
      default: ;
    endcase
    if (state == gcm_pkg::S_MAP_RD1) begin
      // lower stop arrives now
      dp <= {1'b0, key} - {1'b0, pos_rdata};
      p0 <= pos_rdata;
      c0 <= col_rdata;
    end
    if (state == gcm_pkg::S_MAP_WT) ps <= {1'b0, pos_rdata} - {1'b0, p0};
    if (state == gcm_pkg::S_MAP_DIV && div_done && !(chn == 2'd3 && lerp_done_skip)) begin
      res[chn] <= div_quot[7:0];
      chn      <= chn + 1'b1;
    end
    if (state == gcm_pkg::S_OUT && state_next == gcm_pkg::S_IDLE) chn <= 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) lerp_active <= 1'b0;
    else if (state == gcm_pkg::S_MAP_DIFF)
      lerp_active <= status == gcm_pkg::ST_OK && stop_count != '0 && lo != '0 &&
                     lo < stop_count && scaled_mode;
  end
  assign lerp_done_skip = !lerp_active;

  logic [7:0] out_a;
  assign out_a = (status == gcm_pkg::ST_OK && op == gcm_pkg::OP_MAP && !alpha_seen &&
                  stop_count != '0) ? 8'd255 : res[3];
  assign m_tdata = {6'd0, status, out_a, res[2], res[1], res[0]};

  // ---------------- assertions ----------------
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    stop_count <= CntW'(MAX_STOPS)) else $error("stop count overflow");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == gcm_pkg::S_IDLE |-> !ram_we) else $error("RAM write while idle");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == gcm_pkg::ST_EMPTY |-> m_tdata[31:0] == '0)
    else $error("empty range result not zero");
endmodule

>>> design/gcm_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module gcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/gcm_div.sv
// Restoring divider, one quotient bit per cycle: quot = floor(num / den).
// No package dependency.
module gcm_div #(
  parameter int Bits = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [Bits-1:0] num,
  input  logic [Bits-1:0] den,
  output logic            done,
  output logic [Bits-1:0] quot
);
  localparam int CntW = $clog2(Bits + 1);
  logic [Bits-1:0] rem;
  logic [Bits-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [Bits:0]   trial;

  assign trial = {rem, quot[Bits-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(Bits);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dvs  <= den;
    end else if (busy) begin
      if (!trial[Bits]) begin
        rem <= trial[Bits-1:0];
      end else begin
        rem <= {rem[Bits-2:0], quot[Bits-1]};
      end
      quot <= {quot[Bits-2:0], !trial[Bits]};
    end
  end
endmodule
